// ===== src/b2da_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the binary to decimal ASCII formatter.
// No dependencies; imported by every module of the block.
package b2da_pkg;

   // Formatting modes carried by req_opcode
   localparam logic [1:0] OP_U8      = 2'd0;
   localparam logic [1:0] OP_U16     = 2'd1;
   localparam logic [1:0] OP_TEMP    = 2'd2;
   localparam logic [1:0] OP_CURRENT = 2'd3;

   // Power of ten selector for the subtract-and-count unit
   localparam logic [1:0] POW_10000 = 2'd0;
   localparam logic [1:0] POW_1000  = 2'd1;
   localparam logic [1:0] POW_100   = 2'd2;
   localparam logic [1:0] POW_10    = 2'd3;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] UNIT_RESET = 8'h43;

   // One classified job handed from the front to the back
   typedef struct packed {
      logic        prefix_en;    // emit a sign character first
      logic [7:0]  prefix_char;
      logic [15:0] value;        // magnitude to print
      logic [1:0]  pow_idx;      // highest power of ten to try
      logic        force_digits; // no leading zero suppression, dot before units
      logic        suffix_en;    // append the unit character
   } job_type;

   function automatic logic [13:0] pow_value(input logic [1:0] idx);
      logic [13:0] pow;
      unique case (idx)
         POW_10000: pow = 14'd10000;
         POW_1000:  pow = 14'd1000;
         POW_100:   pow = 14'd100;
         POW_10:    pow = 14'd10;
         default:   pow = 14'd10;
      endcase
      return pow;
   endfunction

endpackage

// ===== src/b2da_front.sv =====
`timescale 1ns / 1ps
// Front end: classifies an incoming word into a formatting job.
// Depends on b2da_pkg.
module b2da_front
   import b2da_pkg::*;
(
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_number_in,
   output job_type     job
);

   logic [7:0] byte_val;
   logic [7:0] neg_mag;

   assign byte_val = req_number_in[7:0];
   assign neg_mag  = ~byte_val + 8'd1;

   // Pick sign, magnitude and starting power per mode
   always_comb begin
      job              = '0;
      job.prefix_char  = CHAR_PLUS;
      job.value        = {8'd0, byte_val};
      job.pow_idx      = POW_100;
      unique case (req_opcode)
         OP_U8: begin
         end
         OP_U16: begin
            job.value   = req_number_in;
            job.pow_idx = POW_10000;
         end
         OP_TEMP: begin
            job.prefix_en = 1'b1;
            job.suffix_en = 1'b1;
            if (byte_val[7]) begin
               job.prefix_char = CHAR_MINUS;
               job.value       = {8'd0, neg_mag};
            end
         end
         OP_CURRENT: begin
            job.force_digits = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== src/b2da_fifo.sv =====
`timescale 1ns / 1ps
// Short job queue between the front and the back of the formatter.
// Depends on b2da_pkg for job_type.
module b2da_fifo
   import b2da_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type pop_job,
   output logic    not_empty,
   output logic    full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_job   = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== src/b2da_back.sv =====
`timescale 1ns / 1ps
// Back end: digit sequencer that subtracts powers of ten and emits characters.
// Depends on b2da_pkg.
module b2da_back
   import b2da_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   input  logic [7:0] unit_char,
   output logic       job_pop,
   output logic       rsp_valid,
   output logic [7:0] rsp_ascii_char,
   output logic       rsp_last_char
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PREFIX = 3'd1;
   localparam logic [2:0] ST_DIGIT  = 3'd2;
   localparam logic [2:0] ST_DOT    = 3'd3;
   localparam logic [2:0] ST_UNITS  = 3'd4;
   localparam logic [2:0] ST_SUFFIX = 3'd5;

   logic [2:0]  state_ff, state_in;
   job_type     job_ff, job_in;
   logic [15:0] val_ff, val_in;
   logic [1:0]  pow_ff, pow_in;
   logic [3:0]  dig_ff, dig_in;
   logic        started_ff, started_in;
   logic        valid_ff, valid_in;
   logic [7:0]  char_ff, char_in;
   logic        last_ff, last_in;
   logic [15:0] pow_full;
   logic        ge_pow;

   assign pow_full = {2'd0, pow_value(pow_ff)};
   assign ge_pow   = (val_ff >= pow_full);
   assign job_pop  = (state_ff == ST_IDLE) && job_valid;

   // Sequence one job: sign, digits, dot, units, unit character
   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      val_in     = val_ff;
      pow_in     = pow_ff;
      dig_in     = dig_ff;
      started_in = started_ff;
      valid_in   = 1'b0;
      char_in    = char_ff;
      last_in    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_in     = job;
               val_in     = job.value;
               pow_in     = job.pow_idx;
               dig_in     = '0;
               started_in = 1'b0;
               state_in   = job.prefix_en ? ST_PREFIX : ST_DIGIT;
            end
         end
         ST_PREFIX: begin
            valid_in = 1'b1;
            char_in  = job_ff.prefix_char;
            state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            if (ge_pow) begin
               val_in = val_ff - pow_full;
               dig_in = dig_ff + 4'd1;
            end else begin
               if ((dig_ff != '0) || started_ff || job_ff.force_digits) begin
                  valid_in = 1'b1;
                  char_in  = CHAR_ZERO + {4'd0, dig_ff};
               end
               started_in = started_ff || (dig_ff != '0);
               dig_in     = '0;
               if (pow_ff == POW_10) begin
                  state_in = job_ff.force_digits ? ST_DOT : ST_UNITS;
               end else begin
                  pow_in = pow_ff + 2'd1;
               end
            end
         end
         ST_DOT: begin
            valid_in = 1'b1;
            char_in  = CHAR_DOT;
            state_in = ST_UNITS;
         end
         ST_UNITS: begin
            valid_in = 1'b1;
            char_in  = CHAR_ZERO + {4'd0, val_ff[3:0]};
            last_in  = !job_ff.suffix_en;
            state_in = job_ff.suffix_en ? ST_SUFFIX : ST_IDLE;
         end
         ST_SUFFIX: begin
            valid_in = 1'b1;
            char_in  = unit_char;
            last_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

   // Hold payload and working values
   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      val_ff     <= val_in;
      pow_ff     <= pow_in;
      dig_ff     <= dig_in;
      started_ff <= started_in;
      char_ff    <= char_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_last_char  = last_ff;

endmodule

// ===== src/binary_to_decimal_ascii_formatter_core.sv =====
`timescale 1ns / 1ps
// Each word passes through the job queue, the digit sequencer and the output register; the
// subtractions ahead of the first printed digit set how soon its first character appears.
// The sequencer starts a new word only from idle; its steps are each subtraction in the single
// subtract-and-count unit, each power of ten tried, each sign, point, units or unit character, and idle.
// Results are strobed for one cycle each; the receiver cannot stall.
// Synchronous active-high reset empties the queue and sets the unit character to 'C'.
module binary_to_decimal_ascii_formatter_core
   import b2da_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_number_in,
   input  logic        csr_write_en,
   input  logic [7:0]  csr_write_data,
   output logic        rsp_valid,
   output logic [7:0]  rsp_ascii_char,
   output logic        rsp_last_char
);

   logic [7:0] unit_ff;
   job_type    front_job;
   job_type    queue_job;
   logic       queue_not_empty;
   logic       queue_full;
   logic       queue_pop;

   // Unit character register
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= UNIT_RESET;
      end else if (csr_write_en) begin
         unit_ff <= csr_write_data;
      end
   end

   assign busy = queue_full;

   b2da_front u_front (
      .req_opcode    (req_opcode),
      .req_number_in (req_number_in),
      .job           (front_job)
   );

   b2da_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (start),
      .push_job  (front_job),
      .pop       (queue_pop),
      .pop_job   (queue_job),
      .not_empty (queue_not_empty),
      .full      (queue_full)
   );

   b2da_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (queue_not_empty),
      .job            (queue_job),
      .unit_char      (unit_ff),
      .job_pop        (queue_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char)
   );

endmodule

// ===== src/b2da_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the formatter core, attached by bind.
// Depends on b2da_pkg and binary_to_decimal_ascii_formatter_core.
module b2da_checker
   import b2da_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [7:0]  rsp_ascii_char,
   input logic        rsp_last_char
);

   // Reset leaves the queue empty and no word strobed
   a_reset_idle: assert property (@(posedge clock) reset |=> (!busy && !rsp_valid))
      else $error("busy or strobe right after reset");

   // The last character of a text is followed by a quiet cycle
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_char) |=> !rsp_valid)
      else $error("strobe right after last character");

   // Characters before the last are digits, signs or the decimal point
   a_mid_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_char) |->
         ((rsp_ascii_char >= CHAR_ZERO && rsp_ascii_char <= 8'h39) ||
          rsp_ascii_char == CHAR_PLUS || rsp_ascii_char == CHAR_MINUS ||
          rsp_ascii_char == CHAR_DOT))
      else $error("unexpected character before end of text");

   // The queue only fills on an accepted word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy raised without an accepted word");

endmodule

bind binary_to_decimal_ascii_formatter_core b2da_checker u_b2da_checker (.*);

// ===== tb/binary_to_decimal_ascii_formatter_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for binary_to_decimal_ascii_formatter_core.
// Depends on b2da_pkg and the core; each character is checked against a local formatter model.
module binary_to_decimal_ascii_formatter_core_tb;
   import b2da_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 48;
   localparam int MAX_REPORTS  = 10;
   localparam int RANDOM_WORDS = 67;

   typedef struct packed {
      logic [7:0] ascii_char;
      logic       last_char;
   } text_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = OP_U8;
   logic [15:0] req_number_in = 16'd0;
   logic        csr_write_en = 1'b0;
   logic [7:0]  csr_write_data = 8'd0;
   logic        rsp_valid;
   logic [7:0]  rsp_ascii_char;
   logic        rsp_last_char;

   // Local copy of the unit register and the characters still owed by the core
   logic [7:0]     unit_char_model = UNIT_RESET;
   text_char_type  expected_chars[$];
   text_char_type  text_buf[$];

   int          cycle_count   = 0;
   int          failures      = 0;
   int          words_sent    = 0;
   int          chars_checked = 0;
   int          unit_settings = 1;

   binary_to_decimal_ascii_formatter_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_number_in  (req_number_in),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char)
   );

   always #2 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters pending",
                  cycle_count, expected_chars.size());
         $display("FAIL");
         $finish;
      end
   end

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("[%0d] %s", cycle_count, msg);
   endfunction

   function automatic void push_text_char(input logic [7:0] c);
      text_char_type t;
      t.ascii_char = c;
      t.last_char  = 1'b0;
      text_buf.push_back(t);
   endfunction

   // Count each power of ten by subtraction, drop leading zeros, always keep units
   function automatic void emit_digits(input int unsigned value, input int unsigned pow);
      int unsigned v;
      int unsigned p;
      int unsigned digit;
      bit          leading;
      v = value;
      p = pow;
      leading = 1'b1;
      while (p > 1) begin
         digit = 0;
         while (v >= p) begin
            v -= p;
            digit++;
         end
         if (digit != 0)
            leading = 1'b0;
         if (!leading)
            push_text_char(CHAR_ZERO + 8'(digit));
         p = p / 10;
      end
      push_text_char(CHAR_ZERO + 8'(v));
   endfunction

   // Build the full text of one word and queue it behind older expectations
   function automatic void format_decimal_text(input logic [1:0] opcode,
                                               input logic [15:0] number);
      logic [7:0]     low_byte;
      int unsigned    v;
      int unsigned    tens;
      int unsigned    ones;
      text_char_type  tail;
      low_byte = number[7:0];
      text_buf.delete();
      case (opcode)
         OP_U8: emit_digits(int'(low_byte), 100);
         OP_U16: emit_digits(int'(number), 10000);
         OP_TEMP: begin
            if (low_byte[7]) begin
               push_text_char(CHAR_MINUS);
               emit_digits(256 - int'(low_byte), 100);
            end else begin
               push_text_char(CHAR_PLUS);
               emit_digits(int'(low_byte), 100);
            end
            push_text_char(unit_char_model);
         end
         OP_CURRENT: begin
            v = int'(low_byte);
            tens = 0;
            ones = 0;
            while (v >= 100) begin
               v -= 100;
               tens++;
            end
            while (v >= 10) begin
               v -= 10;
               ones++;
            end
            push_text_char(CHAR_ZERO + 8'(tens));
            push_text_char(CHAR_ZERO + 8'(ones));
            push_text_char(CHAR_DOT);
            push_text_char(CHAR_ZERO + 8'(v));
         end
      endcase
      tail = text_buf.pop_back();
      tail.last_char = 1'b1;
      text_buf.push_back(tail);
      foreach (text_buf[i])
         expected_chars.push_back(text_buf[i]);
   endfunction

   // Compare every strobed character with the oldest expectation
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid) begin
         if (expected_chars.size() == 0) begin
            note_failure($sformatf("unexpected char %h last %b",
                                   rsp_ascii_char, rsp_last_char));
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (rsp_ascii_char !== want.ascii_char || rsp_last_char !== want.last_char)
               note_failure($sformatf("mismatch: expected char %h last %b, got char %h last %b",
                                      want.ascii_char, want.last_char,
                                      rsp_ascii_char, rsp_last_char));
         end
      end
   end

   // Offer one word and hold it until the core takes it; start stays high
   task automatic send_word(input logic [1:0] opcode, input logic [15:0] number);
      @(negedge clock);
      start = 1'b1;
      req_opcode = opcode;
      req_number_in = number;
      do @(posedge clock); while (busy);
      format_decimal_text(opcode, number);
      words_sent++;
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // Drop start and wait for every owed character
   task automatic wait_drained();
      idle_cycles(1);
      while (expected_chars.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_unit(input logic [7:0] unit);
      wait_drained();
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_write_data = unit;
      @(negedge clock);
      csr_write_en = 1'b0;
      unit_char_model = unit;
      unit_settings++;
   endtask

   function automatic logic [15:0] random_number();
      logic [15:0] n;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: n = 16'($urandom);
         4, 5:       n = {8'($urandom), 8'($urandom_range(0, 20))};
         6:          n = {8'($urandom), 8'($urandom_range(120, 135))};
         default:    n = 16'($urandom) >> $urandom_range(0, 15);
      endcase
      return n;
   endfunction

   task automatic test_u8_extremes();
      send_word(OP_U8, 16'd0);
      send_word(OP_U8, 16'd9);
      send_word(OP_U8, 16'd10);
      send_word(OP_U8, 16'd99);
      send_word(OP_U8, 16'd100);
      send_word(OP_U8, 16'd255);
      // high byte must be ignored
      send_word(OP_U8, 16'hFF00);
   endtask

   task automatic test_u16_extremes();
      send_word(OP_U16, 16'd0);
      send_word(OP_U16, 16'd10);
      send_word(OP_U16, 16'd9999);
      send_word(OP_U16, 16'd10000);
      send_word(OP_U16, 16'hFFFF);
   endtask

   task automatic test_temperature_signs();
      send_word(OP_TEMP, 16'h0000);
      send_word(OP_TEMP, 16'h007F);
      // most negative byte keeps its full magnitude
      send_word(OP_TEMP, 16'h0080);
      send_word(OP_TEMP, 16'h00FF);
      send_word(OP_TEMP, 16'hAB05);
   endtask

   task automatic test_current_tenths();
      send_word(OP_CURRENT, 16'd0);
      send_word(OP_CURRENT, 16'd255);
      send_word(OP_CURRENT, 16'h1234);
   endtask

   task automatic test_unit_register();
      write_unit("F");
      send_word(OP_TEMP, 16'h00E7);
      write_unit(8'h00);
      send_word(OP_TEMP, 16'h0001);
      write_unit(8'hFF);
      send_word(OP_TEMP, 16'h009C);
   endtask

   // Random words in bursts, with or without gaps between bursts
   task automatic test_random_words(input int count, input bit with_gaps);
      int left;
      int burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 8);
         while (burst > 0 && left > 0) begin
            send_word(2'($urandom_range(0, 3)), random_number());
            burst--;
            left--;
         end
         if (with_gaps)
            idle_cycles($urandom_range(0, 12));
      end
   endtask

   task automatic test_random_traffic();
      logic [7:0] units[5];
      units = '{"K", 8'h00, 8'hFF, "F", UNIT_RESET};
      foreach (units[i]) begin
         write_unit(units[i]);
         test_random_words(RANDOM_WORDS, (i % 2) == 0);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_u8_extremes();
      test_u16_extremes();
      test_temperature_signs();
      test_current_tenths();
      test_unit_register();
      test_random_traffic();

      idle_cycles(1);
      while (expected_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("formatted %0d words in all four modes, %0d characters checked",
               words_sent, chars_checked);
      $display("unit register held %0d settings, %0d failures", unit_settings, failures);
      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
